[rtl/mhpq_pkg.sv]
`default_nettype none
package mhpq_pkg;
  localparam int unsigned CAPACITY_DEF  = 256;
  localparam int unsigned NODE_BITS_DEF = 16;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_CHANGE = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
endpackage
`default_nettype wire

[rtl/min_heap_priority_queue.sv]
`default_nettype none
// Insert, change and lookup scan the heap entry by entry for the node, then decide;
// insert and change then sift the entry up, or change sifts it down. Pop reads the
// root and the last entry, moves the last entry to the root and sifts it down.
// The result is valid once the operation ends; clear, undefined ops and an empty
// pop end at once. Only one word is in flight: the next is taken after the result.
// Reset: rst clears the entry count and control; heap memory holds no reset value.
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned NODE_BITS = NODE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         op,
  input  wire logic [15:0]        node_id,
  input  wire logic signed [31:0] priority_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              status,
  output logic                    present,
  output logic [15:0]             out_node,
  output logic signed [31:0]      out_priority,
  output logic [8:0]              entry_count
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_CHK, S_DECIDE, S_UP_RD, S_UP_CMP, S_UP_WR, S_DN_RD, S_DN_RD2,
    S_DN_CMP, S_DN_WR, S_POP_RD, S_POP_WR, S_WAIT, S_DONE
  } state_t;

  logic [NODE_BITS-1:0] mem_node [CAPACITY];
  logic signed [31:0]   mem_prio [CAPACITY];

  state_t               state;
  state_t               ret_state;
  logic [CW-1:0]        count;
  logic [2:0]           cur_op;
  logic [NODE_BITS-1:0] cur_node;
  logic signed [31:0]   cur_prio;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        pos;
  logic                 found;
  logic [NODE_BITS-1:0] hold_node;
  logic signed [31:0]   hold_prio;
  logic [NODE_BITS-1:0] lc_node;
  logic signed [31:0]   lc_prio;
  logic                 scan_pending;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [NODE_BITS-1:0] rd_node;
  logic signed [31:0]   rd_prio;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [NODE_BITS-1:0] wr_node;
  logic signed [31:0]   wr_prio;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_node[wr_addr] <= wr_node;
      mem_prio[wr_addr] <= wr_prio;
    end
    if (rd_en) begin
      rd_node <= mem_node[rd_addr];
      rd_prio <= mem_prio[rd_addr];
    end
  end

  logic [IW-1:0] parent_idx, left_idx, right_idx, count_x;
  logic          in_take;
  assign parent_idx = (pos - IW'(1)) >> 1;
  assign left_idx   = {pos[IW-2:0], 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign count_x    = IW'(count);
  assign in_stall   = (state != S_IDLE);
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rd_en     <= 1'b0;
      wr_en     <= 1'b0;
    end else begin
      rd_en <= 1'b0;
      wr_en <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_take) begin
            cur_op       <= op;
            cur_node     <= node_id[NODE_BITS-1:0];
            cur_prio     <= priority_req;
            status       <= ST_OK;
            present      <= 1'b0;
            out_node     <= '0;
            out_priority <= '0;
            idx          <= '0;
            found        <= 1'b0;
            scan_pending <= 1'b0;
            case (op)
              OP_INSERT, OP_CHANGE, OP_LOOKUP: state <= S_SCAN;
              OP_POP: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_DONE;
                end else begin
                  rd_en     <= 1'b1;
                  rd_addr   <= '0;
                  state     <= S_WAIT;
                  ret_state <= S_POP_RD;
                end
              end
              OP_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_pending && rd_node == cur_node) begin
            found <= 1'b1;
            pos   <= idx - IW'(1);
            hold_prio <= rd_prio;
            state <= S_DECIDE;
          end else if (idx >= count_x) begin
            state <= S_DECIDE;
          end else begin
            rd_en        <= 1'b1;
            rd_addr      <= idx[AW-1:0];
            idx          <= idx + IW'(1);
            scan_pending <= 1'b1;
            state        <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: state <= S_SCAN;
        S_WAIT: state <= ret_state;
        S_DECIDE: begin
          case (cur_op)
            OP_INSERT: begin
              if (found) begin
                status <= ST_DUP;
                state  <= S_DONE;
              end else if (count_x >= IW'(CAPACITY)) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else begin
                hold_node <= cur_node;
                hold_prio <= cur_prio;
                pos       <= count_x;
                wr_en     <= 1'b1;
                wr_addr   <= count_x[AW-1:0];
                wr_node   <= cur_node;
                wr_prio   <= cur_prio;
                count     <= count + CW'(1);
                state     <= S_UP_RD;
              end
            end
            OP_CHANGE: begin
              if (!found) begin
                status <= ST_NOTFOUND;
                state  <= S_DONE;
              end else begin
                hold_node <= cur_node;
                wr_en     <= 1'b1;
                wr_addr   <= pos[AW-1:0];
                wr_node   <= cur_node;
                wr_prio   <= cur_prio;
                if (cur_prio < hold_prio) state <= S_UP_RD;
                else state <= S_DN_RD;
                hold_prio <= cur_prio;
              end
            end
            default: begin
              out_node <= 16'(cur_node);
              if (found) begin
                present      <= 1'b1;
                out_priority <= hold_prio;
              end else begin
                status <= ST_NOTFOUND;
              end
              state <= S_DONE;
            end
          endcase
        end
        S_UP_RD: begin
          if (pos == '0) begin
            state <= S_DONE;
          end else begin
            rd_en     <= 1'b1;
            rd_addr   <= parent_idx[AW-1:0];
            state     <= S_WAIT;
            ret_state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (hold_prio < rd_prio) begin
            wr_en   <= 1'b1;
            wr_addr <= pos[AW-1:0];
            wr_node <= rd_node;
            wr_prio <= rd_prio;
            pos     <= parent_idx;
            state   <= S_UP_WR;
          end else begin
            state <= S_DONE;
          end
        end
        S_UP_WR: begin
          wr_en   <= 1'b1;
          wr_addr <= pos[AW-1:0];
          wr_node <= hold_node;
          wr_prio <= hold_prio;
          state   <= S_UP_RD;
        end
        S_POP_RD: begin
          out_node     <= 16'(rd_node);
          out_priority <= rd_prio;
          rd_en        <= 1'b1;
          rd_addr      <= AW'(count - CW'(1));
          count        <= count - CW'(1);
          state        <= S_WAIT;
          ret_state    <= S_POP_WR;
        end
        S_POP_WR: begin
          hold_node <= rd_node;
          hold_prio <= rd_prio;
          pos       <= '0;
          wr_en     <= 1'b1;
          wr_addr   <= '0;
          wr_node   <= rd_node;
          wr_prio   <= rd_prio;
          state     <= S_DN_RD;
        end
        S_DN_RD: begin
          if (left_idx >= count_x) begin
            state <= S_DONE;
          end else begin
            rd_en     <= 1'b1;
            rd_addr   <= left_idx[AW-1:0];
            state     <= S_WAIT;
            ret_state <= S_DN_RD2;
          end
        end
        S_DN_RD2: begin
          rd_en     <= (right_idx < count_x);
          rd_addr   <= right_idx[AW-1:0];
          state     <= S_WAIT;
          ret_state <= S_DN_CMP;
          lc_node   <= rd_node;
          lc_prio   <= rd_prio;
        end
        S_DN_CMP: begin
          if (right_idx < count_x && rd_prio < lc_prio && rd_prio < hold_prio) begin
            wr_en   <= 1'b1;
            wr_addr <= pos[AW-1:0];
            wr_node <= rd_node;
            wr_prio <= rd_prio;
            pos     <= right_idx;
            state   <= S_DN_WR;
          end else if (lc_prio < hold_prio) begin
            wr_en   <= 1'b1;
            wr_addr <= pos[AW-1:0];
            wr_node <= lc_node;
            wr_prio <= lc_prio;
            pos     <= left_idx;
            state   <= S_DN_WR;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_WR: begin
          wr_en   <= 1'b1;
          wr_addr <= pos[AW-1:0];
          wr_node <= hold_node;
          wr_prio <= hold_prio;
          state   <= S_DN_RD;
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            entry_count <= 9'(count);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("count beyond capacity");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_DONE)
    else $error("result outside done");
  assert property (@(posedge clk) disable iff (rst) in_take |=> !out_valid)
    else $error("result with fresh word");
endmodule
`default_nettype wire

[tb/sv/tb_min_heap_priority_queue.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_min_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int unsigned HEAP_DEPTH = 256;
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int N_WORDS = 1900;
  localparam int QUIET_FROM = 1700;

  typedef struct packed {
    logic [2:0]         status;
    logic               present;
    logic [15:0]        node;
    logic signed [31:0] prio;
    logic [8:0]         count;
  } heap_result_t;

  typedef struct {
    logic [2:0]         op;
    logic [15:0]        node;
    logic signed [31:0] prio;
    bit                 known;
    heap_result_t       res;
  } heap_step_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         op;
  logic [15:0]        node_id;
  logic signed [31:0] priority_req;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         status;
  logic               present;
  logic [15:0]        out_node;
  logic signed [31:0] out_priority;
  logic [8:0]         entry_count;

  min_heap_priority_queue u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .node_id(node_id), .priority_req(priority_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .present(present), .out_node(out_node),
    .out_priority(out_priority), .entry_count(entry_count)
  );

  logic [15:0]        heap_id [HEAP_DEPTH];
  logic signed [31:0] heap_pri [HEAP_DEPTH];
  int                 heap_fill;
  heap_result_t       pending_q [$];
  int                 errors;
  int                 words_sent;
  int                 words_checked;
  int                 status_seen [8];
  int                 max_fill;
  bit                 quiet;
  int                 stall_left;

  heap_step_t dir_tab [23] = '{
    '{OP_POP,    16'd0,      32'sd0,        1'b1, '{ST_EMPTY,    1'b0, 16'd0,      32'sd0, 9'd0}},
    '{OP_LOOKUP, 16'hFFFF,   32'sd0,        1'b1, '{ST_NOTFOUND, 1'b0, 16'hFFFF,   32'sd0, 9'd0}},
    '{OP_CHANGE, 16'd5,      32'sd1,        1'b1, '{ST_NOTFOUND, 1'b0, 16'd0,      32'sd0, 9'd0}},
    '{OP_INSERT, 16'hFFFF,   32'h7FFFFFFF,  1'b1, '{ST_OK,       1'b0, 16'd0,      32'sd0, 9'd1}},
    '{OP_INSERT, 16'd0,      32'h80000000,  1'b1, '{ST_OK,       1'b0, 16'd0,      32'sd0, 9'd2}},
    '{OP_INSERT, 16'd0,      32'sd5,        1'b1, '{ST_DUP,      1'b0, 16'd0,      32'sd0, 9'd2}},
    '{OP_LOOKUP, 16'd0,      32'sd0,        1'b1,
      '{ST_OK, 1'b1, 16'd0, 32'h80000000, 9'd2}},
    '{OP_LOOKUP, 16'hFFFF,   32'sd0,        1'b1,
      '{ST_OK, 1'b1, 16'hFFFF, 32'h7FFFFFFF, 9'd2}},
    '{OP_POP,    16'd0,      32'sd0,        1'b1,
      '{ST_OK, 1'b0, 16'd0, 32'h80000000, 9'd1}},
    '{OP_INSERT, 16'd1,      32'sd0,        1'b0, '0},
    '{OP_INSERT, 16'd2,      32'sd0,        1'b0, '0},
    '{OP_INSERT, 16'd3,      32'sd0,        1'b0, '0},
    '{OP_CHANGE, 16'd3,      -32'sd5,       1'b0, '0},
    '{OP_CHANGE, 16'd3,      -32'sd5,       1'b0, '0},
    '{OP_CHANGE, 16'd1,      32'h7FFFFFFF,  1'b0, '0},
    '{OP_CHANGE, 16'hFFFF,   32'h80000000,  1'b0, '0},
    '{OP_POP,    16'd0,      32'sd0,        1'b0, '0},
    '{OP_POP,    16'd0,      32'sd0,        1'b0, '0},
    '{OP_RSVD5,  16'hAAAA,   32'h55555555,  1'b0, '0},
    '{OP_RSVD6,  16'h5555,   32'hAAAAAAAA,  1'b0, '0},
    '{OP_RSVD7,  16'd9,      32'sd9,        1'b0, '0},
    '{OP_CLEAR,  16'd0,      32'sd0,        1'b1, '{ST_OK,       1'b0, 16'd0,      32'sd0, 9'd0}},
    '{OP_POP,    16'd0,      32'sd0,        1'b1, '{ST_EMPTY,    1'b0, 16'd0,      32'sd0, 9'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void heap_swap(int a, int b);
    logic [15:0]        t_id;
    logic signed [31:0] t_pri;
    t_id = heap_id[a];
    t_pri = heap_pri[a];
    heap_id[a] = heap_id[b];
    heap_pri[a] = heap_pri[b];
    heap_id[b] = t_id;
    heap_pri[b] = t_pri;
  endfunction

  function automatic void heap_up(int i);
    int parent;
    while (i > 0) begin
      parent = (i - 1) / 2;
      if (heap_pri[i] < heap_pri[parent]) begin
        heap_swap(i, parent);
        i = parent;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void heap_down(int i);
    int best;
    int l;
    int r;
    while (i < heap_fill) begin
      best = i;
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l < heap_fill && heap_pri[l] < heap_pri[best]) best = l;
      if (r < heap_fill && heap_pri[r] < heap_pri[best]) best = r;
      if (best == i) break;
      heap_swap(i, best);
      i = best;
    end
  endfunction

  function automatic int heap_find(logic [15:0] nd);
    for (int i = 0; i < heap_fill; i++) begin
      if (heap_id[i] == nd) return i;
    end
    return -1;
  endfunction

  function automatic heap_result_t heap_apply(logic [2:0] code, logic [15:0] nd,
                                              logic signed [31:0] pr);
    heap_result_t       r;
    int                 pos;
    logic signed [31:0] old_pri;
    r = '0;
    case (code)
      OP_INSERT: begin
        if (heap_find(nd) >= 0) begin
          r.status = ST_DUP;
        end else if (heap_fill >= HEAP_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          heap_id[heap_fill] = nd;
          heap_pri[heap_fill] = pr;
          heap_fill++;
          heap_up(heap_fill - 1);
        end
      end
      OP_POP: begin
        if (heap_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.node = heap_id[0];
          r.prio = heap_pri[0];
          heap_fill--;
          heap_id[0] = heap_id[heap_fill];
          heap_pri[0] = heap_pri[heap_fill];
          heap_down(0);
        end
      end
      OP_CHANGE: begin
        pos = heap_find(nd);
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          old_pri = heap_pri[pos];
          heap_pri[pos] = pr;
          if (pr < old_pri) heap_up(pos);
          else heap_down(pos);
        end
      end
      OP_LOOKUP: begin
        r.node = nd;
        pos = heap_find(nd);
        if (pos >= 0) begin
          r.present = 1'b1;
          r.prio = heap_pri[pos];
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      OP_CLEAR: heap_fill = 0;
      default: ;
    endcase
    r.count = 9'(heap_fill);
    return r;
  endfunction

  task automatic send_word(logic [2:0] code, logic [15:0] nd, logic signed [31:0] pr,
                           bit known, heap_result_t given);
    heap_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    node_id <= nd;
    priority_req <= pr;
    do @(posedge clk); while (in_stall);
    r = heap_apply(code, nd, pr);
    pending_q = {pending_q, (known ? given : r)};
    status_seen[r.status]++;
    if (heap_fill > max_fill) max_fill = heap_fill;
    words_sent++;
    quiet = (words_sent >= QUIET_FROM);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int mode);
    int                 pick;
    logic [2:0]         code;
    logic [15:0]        nd;
    logic signed [31:0] pr;
    pick = $urandom_range(0, 99);
    case (mode)
      0: code = pick < 80 ? OP_INSERT : pick < 88 ? OP_LOOKUP : pick < 96 ? OP_CHANGE
                : OP_POP;
      1: code = pick < 70 ? OP_POP : pick < 80 ? OP_INSERT : pick < 90 ? OP_CHANGE
                : OP_LOOKUP;
      default: begin
        if (pick < 1) code = OP_CLEAR;
        else if (pick < 2) code = 3'($urandom_range(5, 7));
        else if (pick < 30) code = OP_INSERT;
        else if (pick < 55) code = OP_POP;
        else if (pick < 80) code = OP_CHANGE;
        else code = OP_LOOKUP;
      end
    endcase
    if (heap_fill > 0 && (code == OP_CHANGE || code == OP_LOOKUP || code == OP_INSERT)
        && $urandom_range(0, 99) < (code == OP_INSERT ? 10 : 75))
      nd = heap_id[$urandom_range(0, heap_fill - 1)];
    else if ($urandom_range(0, 9) < 7)
      nd = 16'($urandom_range(0, 299));
    else
      nd = 16'($urandom);
    if ($urandom_range(0, 1) == 0)
      pr = 32'($signed($urandom_range(0, 15)) - 8);
    else
      pr = $signed($urandom);
    send_word(code, nd, pr, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && out_valid && !out_stall) begin
      words_checked++;
      if (pending_q.size() == 0) begin
        $error("unexpected word: status=%0d node=%0h", status, out_node);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (present !== want.present) begin
          $error("present: expected %0d, got %0d", want.present, present);
          errors++;
        end
        if (out_node !== want.node) begin
          $error("out_node: expected %0h, got %0h", want.node, out_node);
          errors++;
        end
        if (out_priority !== want.prio) begin
          $error("out_priority: expected %0h, got %0h", want.prio, out_priority);
          errors++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int mode;
    int span;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_INSERT;
    node_id = '0;
    priority_req = '0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    heap_fill = 0;
    max_fill = 0;
    quiet = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_word(dir_tab[i].op, dir_tab[i].node, dir_tab[i].prio, dir_tab[i].known,
                dir_tab[i].res);
    drain_wait();

    for (int k = 0; k < HEAP_DEPTH + 6; k++)
      send_word(OP_INSERT, 16'(1000 + k * 37), $signed($urandom), 1'b0, '0);
    for (int k = 0; k < 12; k++) send_random(2);
    drain_wait();

    while (words_sent < N_WORDS) begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 200);
      for (int k = 0; k < span && words_sent < N_WORDS; k++) send_random(mode);
    end
    drain_wait();
    repeat (40) @(posedge clk);

    $display("ran %0d words, %0d checked; largest heap %0d entries", words_sent,
             words_checked, max_fill);
    $display("status counts ok/empty/full/dup/notfound: %0d/%0d/%0d/%0d/%0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_DUP], status_seen[ST_NOTFOUND]);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
